FILE: src/xtea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA package
// Shared constants, register indexes, types and the round function.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROUNDS_W = 10;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0]   XTEA_DELTA  = 32'h9E37_79B9;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RST  = 10'd371;

    // Low bit of the key select field of the running sum for the second half round.
    localparam int unsigned SEL_HI_LSB = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 3'd4;

    typedef logic [3:0][WORD_W-1:0] t_key_words;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_xtea_state;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_xtea_cmd;

    typedef struct packed {
        logic done;
    } t_xtea_status;

    // Feistel function: (((x << 4) ^ (x >> 5)) + x) ^ (s + k)
    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] k
    );
        logic [WORD_W-1:0] shifted;
        shifted = (x << 4) ^ (x >> 5);
        return (shifted + x) ^ (s + k);
    endfunction

endpackage
`default_nettype wire

FILE: src/xtea_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA input channel
// Carries one block and its action bit per word.
// ----------------------------------------------------------------------------
interface xtea_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [xtea_pkg::WORD_W-1:0]   first_word;
    logic [xtea_pkg::WORD_W-1:0]   second_word;

    modport source (output valid, output action, output first_word,
                    output second_word, input ready);
    modport sink   (input valid, input action, input first_word,
                    input second_word, output ready);
endinterface
`default_nettype wire

FILE: src/xtea_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA output channel
// Carries one result block per word.
// ----------------------------------------------------------------------------
interface xtea_out_if;
    logic                          valid;
    logic                          ready;
    logic [xtea_pkg::WORD_W-1:0]   out_first_word;
    logic [xtea_pkg::WORD_W-1:0]   out_second_word;

    modport source (output valid, output out_first_word,
                    output out_second_word, input ready);
    modport sink   (input valid, input out_first_word,
                    input out_second_word, output ready);
endinterface
`default_nettype wire

FILE: src/xtea_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA configuration channel
// Carries a register index and write data per word.
// ----------------------------------------------------------------------------
interface xtea_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [xtea_pkg::CFG_IDX_W-1:0]  index;
    logic [xtea_pkg::WORD_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/xtea_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA configuration registers
// Holds the four key words and the round count.
// ----------------------------------------------------------------------------
module xtea_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr_en,
    input  wire logic [xtea_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]     i_wr_data,
    output xtea_pkg::t_key_words                 o_key,
    output logic [xtea_pkg::ROUNDS_W-1:0]        o_round_count
);

    xtea_pkg::t_key_words                 r_key;
    logic [xtea_pkg::ROUNDS_W-1:0]        r_round_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key         <= '0;
            r_round_count <= xtea_pkg::ROUNDS_RST;
        end else if (i_wr_en) begin
            case (i_wr_index)
                xtea_pkg::CFG_KEY_WORD_0:  r_key[0] <= i_wr_data;
                xtea_pkg::CFG_KEY_WORD_1:  r_key[1] <= i_wr_data;
                xtea_pkg::CFG_KEY_WORD_2:  r_key[2] <= i_wr_data;
                xtea_pkg::CFG_KEY_WORD_3:  r_key[3] <= i_wr_data;
                xtea_pkg::CFG_ROUND_COUNT: begin
                    r_round_count <= i_wr_data[xtea_pkg::ROUNDS_W-1:0];
                end
                default: ;  // Unknown indexes are dropped.
            endcase
        end
    end

    assign o_key         = r_key;
    assign o_round_count = r_round_count;

endmodule
`default_nettype wire

FILE: src/xtea_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA datapath
// Block halves, running sum, round counter and one shared half-round unit.
// ----------------------------------------------------------------------------
module xtea_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire xtea_pkg::t_xtea_cmd             i_cmd,
    input  wire logic                            i_action,
    input  wire logic [xtea_pkg::WORD_W-1:0]     i_first_word,
    input  wire logic [xtea_pkg::WORD_W-1:0]     i_second_word,
    input  wire xtea_pkg::t_key_words            i_key,
    input  wire logic [xtea_pkg::ROUNDS_W-1:0]   i_round_count,
    output xtea_pkg::t_xtea_status               o_status,
    output logic [xtea_pkg::WORD_W-1:0]          o_out_first_word,
    output logic [xtea_pkg::WORD_W-1:0]          o_out_second_word
);

    logic [xtea_pkg::WORD_W-1:0]   r_left,  n_left;
    logic [xtea_pkg::WORD_W-1:0]   r_right, n_right;
    logic [xtea_pkg::WORD_W-1:0]   r_sum,   n_sum;
    logic [xtea_pkg::ROUNDS_W-1:0] r_rounds, n_rounds;
    logic                          r_phase, n_phase;
    logic                          r_decrypt, n_decrypt;
    logic [xtea_pkg::WORD_W-1:0]   r_out_first, r_out_second;

    logic                          use_left;
    logic [1:0]                    key_sel;
    logic [xtea_pkg::WORD_W-1:0]   mix_x;
    logic [xtea_pkg::WORD_W-1:0]   mix_f;
    logic [xtea_pkg::WORD_W-1:0]   target;
    logic [xtea_pkg::WORD_W-1:0]   updated;

    // The first half round of encrypt and the second of decrypt mix the
    // right half into the left; the other two mix the left into the right.
    always_comb begin
        use_left = r_phase ^ r_decrypt;
        mix_x    = use_left ? r_left : r_right;
        target   = use_left ? r_right : r_left;
        key_sel  = use_left ? r_sum[xtea_pkg::SEL_HI_LSB +: 2] : r_sum[1:0];
        mix_f    = xtea_pkg::mix(mix_x, r_sum, i_key[key_sel]);
        updated  = r_decrypt ? (target - mix_f) : (target + mix_f);
    end

    always_comb begin
        n_left    = r_left;
        n_right   = r_right;
        n_sum     = r_sum;
        n_rounds  = r_rounds;
        n_phase   = r_phase;
        n_decrypt = r_decrypt;
        if (i_cmd.load) begin
            n_left    = i_first_word;
            n_right   = i_second_word;
            n_decrypt = i_action;
            n_rounds  = '0;
            n_phase   = 1'b0;
            n_sum     = i_action
                      ? xtea_pkg::WORD_W'(xtea_pkg::XTEA_DELTA
                            * xtea_pkg::WORD_W'(i_round_count))
                      : '0;
        end else if (i_cmd.step) begin
            if (use_left) begin
                n_right = updated;
            end else begin
                n_left = updated;
            end
            if (!r_phase) begin
                n_sum = r_decrypt ? (r_sum - xtea_pkg::XTEA_DELTA)
                                  : (r_sum + xtea_pkg::XTEA_DELTA);
            end else begin
                n_rounds = r_rounds + 1'b1;
            end
            n_phase = ~r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_right   <= '0;
            r_sum     <= '0;
            r_rounds  <= '0;
            r_phase   <= 1'b0;
            r_decrypt <= 1'b0;
        end else begin
            r_left    <= n_left;
            r_right   <= n_right;
            r_sum     <= n_sum;
            r_rounds  <= n_rounds;
            r_phase   <= n_phase;
            r_decrypt <= n_decrypt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_first  <= r_left;
            r_out_second <= r_right;
        end
    end

    assign o_status.done     = (r_rounds == i_round_count) && !r_phase;
    assign o_out_first_word  = r_out_first;
    assign o_out_second_word = r_out_second;

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_rounds == '0) && !r_phase)
        else $error("load did not clear the round counter and phase");

    a_phase_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load) |=> (r_phase != $past(r_phase)))
        else $error("half-round phase did not toggle on a step");

endmodule
`default_nettype wire

FILE: src/xtea_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA controller
// Sequences load, half-round steps and result capture; owns output valid.
// ----------------------------------------------------------------------------
module xtea_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    input  wire xtea_pkg::t_xtea_status i_status,
    output xtea_pkg::t_xtea_cmd         o_cmd
);

    xtea_pkg::t_xtea_state r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic                  slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xtea_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        // The result register can take a new block when empty or being read.
        slot_free   = !r_out_valid || i_out_ready;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            xtea_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = xtea_pkg::ST_RUN;
                end
            end
            xtea_pkg::ST_RUN: begin
                if (!i_status.done) begin
                    o_cmd.step = 1'b1;
                end else if (slot_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = xtea_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = xtea_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (!r_out_valid || i_out_ready))
        else $error("capture would overwrite an unread result");

    a_no_step_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !i_status.done)
        else $error("step issued after the last round");

    a_capture_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_out_valid)
        else $error("captured result not presented");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == xtea_pkg::ST_RUN))
        else $error("accepted block did not start a run");

endmodule
`default_nettype wire

FILE: src/xtea_block_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA block cipher engine
// Flow: a block is accepted while idle, then stepped one half round per cycle
//   and at the end of the run captured into the result register.
// Input: a new block is taken only after the previous run has been captured;
//   the single shared half-round unit in the datapath keeps one block in work.
// Reset: synchronous, active low; the key clears to zero, the round count
//   returns to 371, the engine goes idle and the result register empties.
// ----------------------------------------------------------------------------
// Encrypts or decrypts one 64-bit block per input word with a 128-bit key
// held in configuration registers. The controller loads a block, steps the
// datapath through 2*N half rounds and then copies the halves into a result
// register. That register parts the two sides: the engine takes the next
// block while the previous result still waits on the output channel, and
// stalls at the end of a run only if the old result has not been taken.
//
// Decryption starts the running sum at delta times N, computed once at load
// with a single constant multiply; a count of zero passes a block through
// unchanged in both directions. The configuration port is always ready and
// drops writes to unknown indexes.
// ----------------------------------------------------------------------------
module xtea_block_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    xtea_in_if.sink          i_in,
    xtea_out_if.source       o_out,
    xtea_cfg_if.sink         i_cfg
);

    xtea_pkg::t_key_words                 key;
    logic [xtea_pkg::ROUNDS_W-1:0]        round_count;
    xtea_pkg::t_xtea_cmd                  cmd;
    xtea_pkg::t_xtea_status               status;
    logic                                 cfg_wr;

    // Configuration writes are taken in every cycle.
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    xtea_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (cfg_wr),
        .i_wr_index    (i_cfg.index),
        .i_wr_data     (i_cfg.data),
        .o_key         (key),
        .o_round_count (round_count)
    );

    // The controller decides when a word is taken and when a result shows.
    xtea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the block, the running sum and the round counter.
    xtea_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_action          (i_in.action),
        .i_first_word      (i_in.first_word),
        .i_second_word     (i_in.second_word),
        .i_key             (key),
        .i_round_count     (round_count),
        .o_status          (status),
        .o_out_first_word  (o_out.out_first_word),
        .o_out_second_word (o_out.out_second_word)
    );

endmodule
`default_nettype wire

FILE: verif/xtea_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Feeds blocks to the engine under several keys and round counts. Every
// result word is checked against a cycle-free XTEA predictor kept in step
// with the configuration writes that the engine accepts.
// ----------------------------------------------------------------------------
module xtea_block_cipher_tb;

    import xtea_pkg::*;

    // Action bit of an input word.
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // Total number of blocks; the last stretch of them runs with no idling.
    localparam int unsigned TOTAL_BLOCKS = 1610;
    localparam int unsigned QUIET_BLOCKS = 150;
    localparam int unsigned MAX_BURST    = 18;

    // The slowest block runs the maximum count of 1023 round pairs. On top of that come the
    // longest sender gap, the longest receiver stall and some slack for a
    // phase change; the watchdog allows several times that.
    localparam int unsigned WATCHDOG_LIMIT = 4 * (2 * 1023 + 2 + 2 * MAX_BURST + 64);

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } t_block_req;

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } t_cipher_block;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xtea_in_if  blk_in ();
    xtea_out_if blk_out ();
    xtea_cfg_if cfg_wr ();

    xtea_block_cipher DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (blk_in),
        .o_out   (blk_out),
        .i_cfg   (cfg_wr)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Blocks waiting to be offered, and cipher results waiting to come back.
    t_block_req    block_queue[$];
    t_cipher_block expected_blocks[$];

    // Copy of the configuration as the engine should hold it. It is updated
    // only on accepted configuration words, so it follows the engine exactly.
    t_key_words        key_now;
    logic [ROUNDS_W-1:0] rounds_now;

    int unsigned blocks_queued = 0;
    int unsigned blocks_done = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    bit          in_fire = 1'b0;
    bit          quiet = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Feistel function of one half round.
    function automatic logic [WORD_W-1:0] feistel_f(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] k
    );
        return ((((x << 4) ^ (x >> 5)) + x) ^ (s + k));
    endfunction

    // Full XTEA transform of one block. Encryption runs the sum up from
    // zero; decryption starts it at delta times the round count and runs
    // the half rounds backward. A round count of zero passes the block.
    function automatic t_cipher_block xtea_transform(
        input logic                action,
        input logic [WORD_W-1:0]   v0,
        input logic [WORD_W-1:0]   v1,
        input t_key_words          k,
        input logic [ROUNDS_W-1:0] n
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] s;
        y = v0;
        z = v1;
        if (action == ACT_ENCRYPT) begin
            s = '0;
            for (int unsigned r = 0; r < n; r++) begin
                y = y + feistel_f(z, s, k[s[1:0]]);
                s = s + XTEA_DELTA;
                z = z + feistel_f(y, s, k[s[SEL_HI_LSB +: 2]]);
            end
        end else begin
            s = XTEA_DELTA * {{(WORD_W - ROUNDS_W){1'b0}}, n};
            for (int unsigned r = 0; r < n; r++) begin
                z = z - feistel_f(y, s, k[s[SEL_HI_LSB +: 2]]);
                s = s - XTEA_DELTA;
                y = y - feistel_f(z, s, k[s[1:0]]);
            end
        end
        return '{first_word: y, second_word: z};
    endfunction

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    // Runs on the falling edge. A new block is presented once the previous
    // word was taken or the channel was idle. After a taken word the driver
    // sometimes holds back for a burst of cycles, so that gaps land at every
    // point of the engine's work: during a run, at the capture cycle and
    // while a result is still waiting on the output.
    int unsigned in_gap = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            blk_in.valid <= 1'b0;
        end else if (!blk_in.valid || in_fire) begin
            if (in_fire && !quiet && $urandom_range(0, 3) == 0) begin
                in_gap = $urandom_range(1, MAX_BURST);
            end
            if (in_gap != 0) begin
                in_gap = in_gap - 1;
                blk_in.valid <= 1'b0;
            end else if (block_queue.size() != 0) begin
                t_block_req req;
                req = block_queue.pop_front();
                blk_in.valid       <= 1'b1;
                blk_in.action      <= req.action;
                blk_in.first_word  <= req.first_word;
                blk_in.second_word <= req.second_word;
            end else begin
                blk_in.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure
    // ------------------------------------------------------------------------
    // The receiver stalls in random bursts, independent of whether a result
    // is on offer, so that stalls also hit the engine's end-of-run wait.
    int unsigned out_stall = 0;

    always @(negedge i_clk) begin
        if (out_stall != 0) begin
            out_stall = out_stall - 1;
            blk_out.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            out_stall = $urandom_range(1, MAX_BURST) - 1;
            blk_out.ready <= 1'b0;
        end else begin
            blk_out.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------------
    // Samples on the rising edge, where all three channels hand over a word.
    // A taken block is pushed as an expected result before the output is
    // checked, so that a pass-through block can never race its own result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_now     = '0;
            rounds_now  = ROUNDS_RST;
            in_fire     = 1'b0;
            idle_cycles = idle_cycles + 1;
        end else begin
            bit any_fire;
            any_fire = 1'b0;

            if (cfg_wr.valid && cfg_wr.ready) begin
                any_fire = 1'b1;
                // Unknown indexes are dropped; the round count keeps only
                // its low bits.
                if (cfg_wr.index <= CFG_KEY_WORD_3) begin
                    key_now[cfg_wr.index[1:0]] = cfg_wr.data;
                end else if (cfg_wr.index == CFG_ROUND_COUNT) begin
                    rounds_now = cfg_wr.data[ROUNDS_W-1:0];
                end
            end

            in_fire = blk_in.valid && blk_in.ready;
            if (in_fire) begin
                any_fire = 1'b1;
                expected_blocks.push_back(xtea_transform(blk_in.action,
                    blk_in.first_word, blk_in.second_word, key_now, rounds_now));
            end

            if (blk_out.valid && blk_out.ready) begin
                any_fire = 1'b1;
                blocks_done = blocks_done + 1;
                if (expected_blocks.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %08h %08h",
                             $time, blk_out.out_first_word, blk_out.out_second_word);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    t_cipher_block exp_blk;
                    exp_blk = expected_blocks.pop_front();
                    if (blk_out.out_first_word !== exp_blk.first_word) begin
                        $display("%0t: out_first_word mismatch, expected %08h actual %08h",
                                 $time, exp_blk.first_word, blk_out.out_first_word);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (blk_out.out_second_word !== exp_blk.second_word) begin
                        $display("%0t: out_second_word mismatch, expected %08h actual %08h",
                                 $time, exp_blk.second_word, blk_out.out_second_word);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end

            idle_cycles = any_fire ? 0 : idle_cycles + 1;
        end
    end

    // The watchdog ends a run in which nothing has moved for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("xtea_block_cipher_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // A random 32-bit word, with the all-zero and all-one words favored.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_block(
        input logic              action,
        input logic [WORD_W-1:0] v0,
        input logic [WORD_W-1:0] v1
    );
        block_queue.push_back('{action: action, first_word: v0, second_word: v1});
        blocks_queued = blocks_queued + 1;
    endfunction

    // Queues a block and, right behind it, the block that undoes it, the
    // way a real user round-trips data through the engine.
    function automatic void queue_round_trip(
        input logic              action,
        input logic [WORD_W-1:0] v0,
        input logic [WORD_W-1:0] v1
    );
        t_cipher_block res;
        res = xtea_transform(action, v0, v1, key_now, rounds_now);
        queue_block(action, v0, v1);
        queue_block(~action, res.first_word, res.second_word);
    endfunction

    // Presents one configuration word and waits until it is taken. The
    // valid stays high across back-to-back writes; end_config lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge i_clk);
        cfg_wr.valid <= 1'b1;
        cfg_wr.index <= idx;
        cfg_wr.data  <= value;
        @(posedge i_clk);
        while (!cfg_wr.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic end_config();
        @(negedge i_clk);
        cfg_wr.valid <= 1'b0;
    endtask

    task automatic load_config(input t_key_words k, input logic [WORD_W-1:0] rounds_data);
        write_reg(CFG_KEY_WORD_0, k[0]);
        write_reg(CFG_KEY_WORD_1, k[1]);
        write_reg(CFG_KEY_WORD_2, k[2]);
        write_reg(CFG_KEY_WORD_3, k[3]);
        write_reg(CFG_ROUND_COUNT, rounds_data);
        end_config();
    endtask

    // Waits until every queued block has come back as a result word. The
    // engine is then idle and may be reconfigured.
    task automatic wait_drained();
        @(negedge i_clk);
        while (blocks_done != blocks_queued) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_key_words          keys;
        logic [ROUNDS_W-1:0] n;
        logic [WORD_W-1:0]   rounds_data;
        int unsigned         sel;
        int unsigned         count;

        // Every input is at a known value before the first edge.
        i_rst_n             = 1'b0;
        blk_in.valid        = 1'b0;
        blk_in.action       = ACT_ENCRYPT;
        blk_in.first_word   = '0;
        blk_in.second_word  = '0;
        blk_out.ready       = 1'b1;
        cfg_wr.valid        = 1'b0;
        cfg_wr.index        = CFG_KEY_WORD_0;
        cfg_wr.data         = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration: an all-zero key and 371 round pairs.
        queue_block(ACT_ENCRYPT, '0, '0);
        queue_block(ACT_DECRYPT, '1, '1);
        wait_drained();

        // All-one key. An all-one round count word is cut to 1023, the
        // slowest setting.
        load_config('1, '1);
        queue_block(ACT_ENCRYPT, '1, '0);
        queue_block(ACT_DECRYPT, '0, '1);
        wait_drained();

        // Standard 32 round pairs with a patterned key, including a round
        // trip and single set bits at both ends of the halves.
        load_config({32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203}, 32'd32);
        queue_round_trip(ACT_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
        queue_block(ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        queue_block(ACT_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        wait_drained();

        // Smallest nonzero round count.
        load_config({$urandom(), $urandom(), $urandom(), $urandom()}, 32'd1);
        queue_block(ACT_ENCRYPT, $urandom(), $urandom());
        queue_block(ACT_DECRYPT, $urandom(), $urandom());
        wait_drained();

        // A count word of 0x400 leaves zero in the register: no rounds at
        // all, so both directions pass the block through.
        load_config({$urandom(), $urandom(), $urandom(), $urandom()}, 32'h0000_0400);
        queue_block(ACT_ENCRYPT, $urandom(), $urandom());
        queue_block(ACT_DECRYPT, $urandom(), $urandom());
        wait_drained();

        // Writes to the unused indexes must leave key and count alone; an
        // engine that aliased them onto real registers shows it here.
        load_config({$urandom(), $urandom(), $urandom(), $urandom()}, 32'd2);
        for (int i = CFG_ROUND_COUNT + 1; i < (1 << CFG_IDX_W); i++) begin
            write_reg(CFG_IDX_W'(i), '1);
        end
        end_config();
        queue_block(ACT_ENCRYPT, $urandom(), $urandom());
        queue_block(ACT_DECRYPT, $urandom(), $urandom());
        wait_drained();

        // Random phases. Most use short round counts to keep the run fast;
        // a few take the reset count, the maximum or zero.
        while (blocks_queued < TOTAL_BLOCKS) begin
            quiet = (blocks_queued >= TOTAL_BLOCKS - QUIET_BLOCKS);

            for (int w = 0; w < 4; w++) begin
                keys[w] = pick_word();
            end
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                n = ROUNDS_W'($urandom_range(1, 16));
            end else if (sel < 90) begin
                n = ROUNDS_W'($urandom_range(17, 64));
            end else if (sel < 96) begin
                n = ROUNDS_W'($urandom_range(65, 400));
            end else begin
                case ($urandom_range(0, 2))
                    0:       n = ROUNDS_RST;
                    1:       n = '1;
                    default: n = '0;
                endcase
            end
            // Now and then junk in the upper bits of the count word, which
            // the register must drop.
            rounds_data = {{(WORD_W - ROUNDS_W){1'b0}}, n};
            if ($urandom_range(0, 3) == 0) begin
                rounds_data[WORD_W-1:ROUNDS_W] = $urandom();
            end
            load_config(keys, rounds_data);

            if (n > 400) begin
                count = $urandom_range(1, 3);
            end else if (n > 64) begin
                count = $urandom_range(4, 10);
            end else begin
                count = $urandom_range(10, 60);
            end

            for (int unsigned b = 0; b < count && blocks_queued < TOTAL_BLOCKS; b++) begin
                if ($urandom_range(0, 3) == 0) begin
                    queue_round_trip(1'($urandom_range(0, 1)), pick_word(), pick_word());
                end else begin
                    queue_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
                end
            end
            wait_drained();
        end

        // Let a full run's worth of cycles pass to catch a stray result.
        repeat (2 * int'(rounds_now) + 20) @(posedge i_clk);

        if (expected_blocks.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, expected_blocks.size());
            mismatch_count = mismatch_count + 1;
        end
        if (mismatch_count == 0) begin
            $display("xtea_block_cipher_tb: clean");
        end else begin
            $display("xtea_block_cipher_tb: errors");
        end
        $finish;
    end

endmodule

FILE: xtea_block_cipher.f
src/xtea_pkg.sv
src/xtea_in_if.sv
src/xtea_out_if.sv
src/xtea_cfg_if.sv
src/xtea_cfg_regs.sv
src/xtea_dpath.sv
src/xtea_ctrl.sv
src/xtea_block_cipher.sv
verif/xtea_block_cipher_tb.sv
